// File: rtl/spi_div_pkg.sv
// Shared constants, codes and helpers for the serial clock divider search.
// No dependencies; the divider search and the checker import this package.
`timescale 1ns / 1ps
`default_nettype none
package spi_div_pkg;

	localparam int unsigned POW_STEPS_DEF = 15;
	localparam int unsigned ODD_STEPS_DEF = 255;

	localparam logic [31:0] SRC_CLOCK_RESET = 32'd600000000;

	localparam int unsigned APB_AW = 2;
	localparam logic [APB_AW-1:0] REG_SRC_CLOCK = '0;

	typedef enum logic {
		SWP_IDLE,
		SWP_DIV
	} sweep_state_t;

	function automatic logic [31:0] absdiff(input logic [31:0] a, input logic [31:0] b);
		absdiff = (a > b) ? (a - b) : (b - a);
	endfunction

	// exact floor(n / d) for any 32-bit n is (n * M) >> (32 + l), with l = clog2(d)
	// and M = ceil(2^(32+l) / d); M always has bit 32 set, so keep its low word
	function automatic logic [31:0] recip_lo(input int unsigned d);
		logic [63:0] m;
		m = ((64'd1 << (32 + $clog2(d))) + 64'(d) - 64'd1) / 64'(d);
		recip_lo = m[31:0];
	endfunction

	function automatic logic [3:0] recip_sh(input int unsigned d);
		recip_sh = 4'($clog2(d));
	endfunction

endpackage
`default_nettype wire

// File: rtl/spi_div_if.sv
// Request and result channel interfaces of the divider search.
// Plain valid/ready channels; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
interface spi_div_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] target_hz;

	modport source (output valid, output target_hz, input ready);
	modport sink   (input valid, input target_hz, output ready);
endinterface

interface spi_div_rsp_if;
	logic        valid;
	logic        ready;
	logic        odd_mode;
	logic [3:0]  power_exponent;
	logic [7:0]  odd_index;
	logic [31:0] achieved_hz;

	modport source (output valid, output odd_mode, output power_exponent,
		output odd_index, output achieved_hz, input ready);
	modport sink   (input valid, input odd_mode, input power_exponent,
		input odd_index, input achieved_hz, output ready);
endinterface
`default_nettype wire

// File: rtl/spi_clock_divider_search.sv
// Serial clock divider search: compare-cell pipeline, candidate table, output skid.
// Depends on spi_div_pkg and the channel interfaces in spi_div_if.sv.
//
//   channel | dir | beat content
//   --------+-----+------------------------------------------------------
//   req     | in  | target_hz
//   rsp     | out | odd_mode, power_exponent, odd_index, achieved_hz
//   apb     | in  | source_clock_hz at byte address 0
//
// One request per cycle while the table is not being filled and the skid register
// is empty; a result passes through the compare cells and a final stage register.
// After reset and after each write of source_clock_hz, req.ready stays low
// while a two-stage reciprocal multiplier fills the odd candidate table,
// one entry a cycle.
// A stalled rsp parks one result in a skid register and freezes the cells.
`timescale 1ns / 1ps
`default_nettype none
module spi_clock_divider_search
	import spi_div_pkg::*;
#(
	parameter int unsigned POW_STEPS = POW_STEPS_DEF,
	parameter int unsigned ODD_STEPS = ODD_STEPS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	spi_div_req_if.sink            req,
	spi_div_rsp_if.source          rsp,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam int unsigned NSTG = (POW_STEPS > ODD_STEPS) ? POW_STEPS : ODD_STEPS;
	localparam int unsigned IWC  = $clog2(NSTG + 1);
	localparam int unsigned IW   = (IWC < 8) ? 8 : IWC;
	localparam int unsigned KW   = $clog2(ODD_STEPS + 1);

	// configuration
	logic        cfg_wr;
	logic [31:0] src_q;

	assign cfg_wr = psel & penable & pwrite & (paddr == REG_SRC_CLOCK);
	assign pready = 1'b1;
	assign prdata = src_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= SRC_CLOCK_RESET;
		end else if (cfg_wr) begin
			src_q <= pwdata;
		end
	end

	// candidate table fill: src / (2k+1) by reciprocal multiplication
	sweep_state_t state_q, state_nx;
	logic [KW-1:0] k_q;
	logic [31:0]   cand_q [0:ODD_STEPS];
	logic [31:0]   rcp_lo [0:ODD_STEPS];
	logic [3:0]    rcp_sh [0:ODD_STEPS];
	logic          mul_v_q;
	logic [KW-1:0] mul_k_q;
	logic [63:0]   mul_p_q;
	logic [64:0]   rsum;
	logic [64:0]   rquo;
	logic          last_k;
	logic          busy;

	for (genvar g = 0; g <= ODD_STEPS; g++) begin : g_rcp
		assign rcp_lo[g] = recip_lo(2 * g + 1);
		assign rcp_sh[g] = recip_sh(2 * g + 1);
	end

	// add back the 2^32 bit of the multiplier as src << 32
	assign rsum   = {1'b0, src_q, 32'd0} + {1'b0, mul_p_q};
	assign rquo   = rsum >> (7'd32 + {3'b000, rcp_sh[mul_k_q]});
	assign last_k = (k_q == KW'(ODD_STEPS));
	assign busy   = (state_q != SWP_IDLE) || mul_v_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			SWP_IDLE: begin
				if (cfg_wr) state_nx = SWP_DIV;
			end
			SWP_DIV: begin
				if (cfg_wr) state_nx = SWP_DIV;
				else if (last_k) state_nx = SWP_IDLE;
			end
			default: state_nx = SWP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SWP_DIV;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			mul_v_q <= 1'b0;
		end else if (cfg_wr) begin
			k_q     <= '0;
			mul_v_q <= 1'b0;
		end else begin
			mul_v_q <= (state_q == SWP_DIV);
			if (state_q == SWP_DIV) k_q <= k_q + KW'(1);
		end
	end

	always_ff @(posedge clk) begin
		mul_k_q <= k_q;
		mul_p_q <= 64'(src_q) * 64'(rcp_lo[k_q]);
		if (mul_v_q && !cfg_wr) cand_q[mul_k_q] <= rquo[31:0];
	end

	// compare cells
	logic          skid_v_q;
	logic          en;
	logic          take;

	assign en        = !skid_v_q;
	assign req.ready = en && !busy;
	assign take      = req.valid && req.ready;

	logic          v_s   [0:NSTG-1];
	logic [31:0]   t_s   [0:NSTG-1];
	logic [31:0]   b1_s  [0:NSTG-1];
	logic [31:0]   d1_s  [0:NSTG-1];
	logic [IW-1:0] i1_s  [0:NSTG-1];
	logic [31:0]   b2_s  [0:NSTG-1];
	logic [31:0]   d2_s  [0:NSTG-1];
	logic [IW-1:0] i2_s  [0:NSTG-1];
	logic          f2_s  [0:NSTG-1];

	for (genvar j = 0; j < NSTG; j++) begin : g_cell
		logic          v_in;
		logic [31:0]   t_in, b1_in, d1_in, b2_in, d2_in;
		logic [IW-1:0] i1_in, i2_in;
		logic          f2_in;
		logic [31:0]   b1_nx, d1_nx, b2_nx, d2_nx;
		logic [IW-1:0] i1_nx, i2_nx;
		logic          f2_nx;

		if (j == 0) begin : g_head
			// best starts at zero, so its distance is the target itself
			assign v_in  = take;
			assign t_in  = req.target_hz;
			assign b1_in = '0;
			assign d1_in = req.target_hz;
			assign i1_in = '0;
			assign b2_in = '0;
			assign d2_in = req.target_hz;
			assign i2_in = '0;
			assign f2_in = 1'b0;
		end else begin : g_link
			assign v_in  = v_s[j-1];
			assign t_in  = t_s[j-1];
			assign b1_in = b1_s[j-1];
			assign d1_in = d1_s[j-1];
			assign i1_in = i1_s[j-1];
			assign b2_in = b2_s[j-1];
			assign d2_in = d2_s[j-1];
			assign i2_in = i2_s[j-1];
			assign f2_in = f2_s[j-1];
		end

		if (j < POW_STEPS) begin : g_pow
			logic [31:0] c1, e1;
			assign c1 = src_q >> j;
			assign e1 = absdiff(t_in, c1);
			always_comb begin
				b1_nx = b1_in;
				d1_nx = d1_in;
				i1_nx = i1_in;
				if (e1 < d1_in) begin
					b1_nx = c1;
					d1_nx = e1;
					i1_nx = IW'(j);
				end
			end
		end else begin : g_pow_pass
			assign b1_nx = b1_in;
			assign d1_nx = d1_in;
			assign i1_nx = i1_in;
		end

		if (j < ODD_STEPS) begin : g_odd
			logic [31:0] e2;
			assign e2 = absdiff(t_in, cand_q[j]);
			always_comb begin
				b2_nx = b2_in;
				d2_nx = d2_in;
				i2_nx = i2_in;
				f2_nx = f2_in;
				if (e2 < d2_in) begin
					b2_nx = cand_q[j];
					d2_nx = e2;
					i2_nx = IW'(j);
					f2_nx = 1'b1;
				end
			end
		end else begin : g_odd_pass
			assign b2_nx = b2_in;
			assign d2_nx = d2_in;
			assign i2_nx = i2_in;
			assign f2_nx = f2_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				t_s[j]  <= t_in;
				b1_s[j] <= b1_nx;
				d1_s[j] <= d1_nx;
				i1_s[j] <= i1_nx;
				b2_s[j] <= b2_nx;
				d2_s[j] <= d2_nx;
				i2_s[j] <= i2_nx;
				f2_s[j] <= f2_nx;
			end
		end
	end

	// final stage: odd fallback and mode choice
	logic [31:0]   lt;
	logic [31:0]   fb2, fd2;
	logic [IW-1:0] fi2;
	logic          odd_nx;

	assign lt  = t_s[NSTG-1];
	assign fb2 = f2_s[NSTG-1] ? b2_s[NSTG-1] : cand_q[ODD_STEPS];
	assign fi2 = f2_s[NSTG-1] ? i2_s[NSTG-1] : IW'(ODD_STEPS);
	assign fd2 = f2_s[NSTG-1] ? d2_s[NSTG-1] : absdiff(lt, cand_q[ODD_STEPS]);

	always_comb begin
		if (b1_s[NSTG-1] == lt)   odd_nx = 1'b0;
		else if (fb2 == lt)       odd_nx = 1'b1;
		else                      odd_nx = !(d1_s[NSTG-1] < fd2);
	end

	logic        fin_v_s;
	logic        fin_odd_s;
	logic [3:0]  fin_pe_s;
	logic [7:0]  fin_oi_s;
	logic [31:0] fin_hz_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s <= 1'b0;
		end else if (en) begin
			fin_v_s <= v_s[NSTG-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_odd_s <= odd_nx;
			fin_pe_s  <= i1_s[NSTG-1][3:0];
			fin_oi_s  <= fi2[7:0];
			fin_hz_s  <= odd_nx ? fb2 : b1_s[NSTG-1];
		end
	end

	// skid: park the final beat when rsp stalls, freeze the cells behind it
	logic        sk_odd_q;
	logic [3:0]  sk_pe_q;
	logic [7:0]  sk_oi_q;
	logic [31:0] sk_hz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (rsp.ready) skid_v_q <= 1'b0;
		end else if (fin_v_s && !rsp.ready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			sk_odd_q <= fin_odd_s;
			sk_pe_q  <= fin_pe_s;
			sk_oi_q  <= fin_oi_s;
			sk_hz_q  <= fin_hz_s;
		end
	end

	assign rsp.valid          = skid_v_q | fin_v_s;
	assign rsp.odd_mode       = skid_v_q ? sk_odd_q : fin_odd_s;
	assign rsp.power_exponent = skid_v_q ? sk_pe_q  : fin_pe_s;
	assign rsp.odd_index      = skid_v_q ? sk_oi_q  : fin_oi_s;
	assign rsp.achieved_hz    = skid_v_q ? sk_hz_q  : fin_hz_s;

endmodule
`default_nettype wire

// File: rtl/spi_div_chk.sv
// Port-level checker for spi_clock_divider_search, bound to the top level.
// Depends on spi_div_pkg; the bind reaches the channel interfaces of the search.
`timescale 1ns / 1ps
`default_nettype none
module spi_div_chk
	import spi_div_pkg::*;
#(
	parameter int unsigned POW_STEPS = POW_STEPS_DEF
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_ready,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire logic              rsp_odd_mode,
	input wire logic [3:0]        rsp_power_exponent,
	input wire logic [7:0]        rsp_odd_index,
	input wire logic [31:0]       rsp_achieved_hz,
	input wire logic              psel,
	input wire logic              penable,
	input wire logic              pwrite,
	input wire logic [APB_AW-1:0] paddr,
	input wire logic              pready
);

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_odd_mode)
			&& $stable(rsp_power_exponent) && $stable(rsp_odd_index)
			&& $stable(rsp_achieved_hz))
		else $error("rsp beat changed while stalled");

	// exponent comes from the power cells only
	a_exp_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (POW_STEPS > 16) || (32'(rsp_power_exponent) < POW_STEPS))
		else $error("power exponent out of range");

	// a source clock write starts the table fill
	a_fill_block: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && (paddr == REG_SRC_CLOCK) |=> !req_ready)
		else $error("request taken during table fill");

	// nothing can be taken right after reset, the table is being filled
	a_reset_block: assert property (@(posedge clk)
		$rose(arst_n) |-> !req_ready)
		else $error("request ready before table fill");

endmodule

bind spi_clock_divider_search spi_div_chk #(.POW_STEPS(POW_STEPS)) u_chk (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_odd_mode       (rsp.odd_mode),
	.rsp_power_exponent (rsp.power_exponent),
	.rsp_odd_index      (rsp.odd_index),
	.rsp_achieved_hz    (rsp.achieved_hz),
	.psel               (psel),
	.penable            (penable),
	.pwrite             (pwrite),
	.paddr              (paddr),
	.pready             (pready)
);
`default_nettype wire
